/* hdl/gsg_pkg.sv */
// Shared constants, types and tables of the Gaussian sample generator.
package gsg_pkg;

    localparam int          MT_N        = 624;
    localparam int          MT_M        = 397;
    localparam int          IDX_W       = 10;
    localparam logic [31:0] SEED_RESET  = 32'd5489;
    localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX_A = 32'h9908B0DF;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam int          CORDIC_STEPS = 30;
    localparam int          STEP_W      = 5;
    localparam int          SAMPLE_W    = 24;

    // Command codes passed from the front end to the back end
    localparam logic CMD_SPARE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [31:0] data;
    } word_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] mt_temper(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & 32'h9D2C5680);
        t = t ^ ((t << 15) & 32'hEFC60000);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

/* hdl/gaussian_sample_generator_core.sv */
// Top level of the Gaussian sample generator: front end, twister, radius unit, back end.
//
// Usage:
//   Input side is a queue: drive request with push; a transaction completes when
//   push is high and full is low. request = 0 is taken and dropped; request = 1
//   asks for one standard normal sample.
//   Output side is a queue: while empty is low, sample and from_spare show the
//   oldest result; pop takes it. A stalled receiver simply leaves it in place.
//   seed_we/seed_wdata load a new seed; write it only while the block is idle.
// Sequence:
//   Odd requests draw two twister words (one memory read port shared by three
//   reads each) and run the radius unit: a normalise loop, 32 log2 squaring
//   steps, the product states Y, MULL and MULH, and 32 root steps. A 30-step
//   CORDIC, the mapping to a sample and the output register follow.
//   Even requests return the held sine half.
//   Up to two requests queue in the front end while the back end works.
// Reset:
//   The seed returns to 5489 and a seeding pass fills all 624 twister
//   memory words; requests queue meanwhile. A seed write repeats the pass
//   and drops any held spare.
module gaussian_sample_generator_core
    import gsg_pkg::*;
#(
    parameter int FRAC_BITS = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       request,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       from_spare,
    input  logic                       seed_we,
    input  logic [31:0]                seed_wdata
);

    logic        cmd_valid;
    logic        cmd;
    logic        cmd_pop;
    logic        word_req;
    word_t       word;
    logic        rad_start;
    logic [31:0] rad_x;
    logic        rad_done;
    logic [30:0] rad_r;

    // Classify requests and queue commands
    gsg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .seed_we   (seed_we),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // Supply tempered words one at a time
    gsg_twister u_twister (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .word_req   (word_req),
        .word       (word)
    );

    // Form the Box-Muller radius from the first word
    gsg_radius u_radius (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rad_start),
        .x     (rad_x),
        .done  (rad_done),
        .r     (rad_r)
    );

    // Rotate, hold the spare and drive the result register
    gsg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .word_req   (word_req),
        .word       (word),
        .rad_start  (rad_start),
        .rad_x      (rad_x),
        .rad_done   (rad_done),
        .rad_r      (rad_r),
        .empty      (empty),
        .pop        (pop),
        .sample     (sample),
        .from_spare (from_spare)
    );

endmodule

/* hdl/gsg_front.sv */
// Front end: request acceptance, spare/draw classification and command queue.
module gsg_front
    import gsg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic request,
    output logic full,
    input  logic seed_we,
    input  logic cmd_pop,
    output logic cmd_valid,
    output logic cmd
);

    logic       q_reg [0:1];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       draw_next_reg, draw_next_next;
    logic       enq, deq;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign enq       = push && !full && request;
    assign deq       = cmd_pop && cmd_valid;

    always_comb
    begin
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        draw_next_next = draw_next_reg;
        if (enq)
        begin
            wr_ptr_next    = !wr_ptr_reg;
            draw_next_next = !draw_next_reg;
        end
        if (deq)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 2'd1;
        end
        // a new seed means the next request draws afresh
        if (seed_we)
        begin
            draw_next_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 2'd0;
            rd_ptr_reg    <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            draw_next_reg <= 1'b1;
        end
        else
        begin
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            draw_next_reg <= draw_next_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= draw_next_reg ? CMD_DRAW : CMD_SPARE;
        end
    end

endmodule

/* hdl/gsg_twister.sv */
// MT19937 word source with seeding pass and on-demand twist of one word per word request.
module gsg_twister
    import gsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    input  logic        word_req,
    output word_t       word
);

    localparam logic [2:0] TW_SEED = 3'd0;
    localparam logic [2:0] TW_IDLE = 3'd1;
    localparam logic [2:0] TW_RA   = 3'd2;
    localparam logic [2:0] TW_RB   = 3'd3;
    localparam logic [2:0] TW_RC   = 3'd4;
    localparam logic [2:0] TW_RD   = 3'd5;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MT_N - 1);

    logic [31:0]      mem [0:MT_N-1];
    logic [31:0]      rd_data_reg;
    logic [2:0]       state_reg, state_next;
    logic [31:0]      seed_reg, seed_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      prev_reg, prev_next;
    logic [31:0]      a_reg, a_next;
    logic [31:0]      b_reg, b_next;

    logic [IDX_W-1:0] idx_inc, idx_m, rd_addr, wr_addr;
    logic [IDX_W:0]   idx_sum;
    logic [31:0]      mix, seed_word, v, twisted, wr_data;
    logic             wr_en;

    assign idx_inc   = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign idx_sum   = {1'b0, idx_reg} + (IDX_W+1)'(MT_M);
    assign idx_m     = (idx_sum >= (IDX_W+1)'(MT_N)) ? IDX_W'(idx_sum - (IDX_W+1)'(MT_N))
                                                      : idx_sum[IDX_W-1:0];
    assign mix       = prev_reg ^ (prev_reg >> 30);
    assign seed_word = (idx_reg == '0) ? seed_reg
                                       : (MT_INIT_MUL * mix) + {22'd0, idx_reg};
    assign v         = (a_reg & 32'h80000000) | (b_reg & 32'h7FFFFFFF);
    assign twisted   = rd_data_reg ^ (v >> 1) ^ (v[0] ? MT_MATRIX_A : 32'd0);

    assign word.valid = (state_reg == TW_RD);
    assign word.data  = mt_temper(twisted);

    always_comb
    begin
        case (state_reg)
            TW_RA:   rd_addr = idx_reg;
            TW_RB:   rd_addr = idx_inc;
            TW_RC:   rd_addr = idx_m;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        seed_next  = seed_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = twisted;
        case (state_reg)
            TW_SEED:
            begin
                wr_en     = 1'b1;
                wr_data   = seed_word;
                prev_next = seed_word;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = TW_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            TW_IDLE:
            begin
                if (word_req)
                begin
                    state_next = TW_RA;
                end
            end
            TW_RA:
            begin
                state_next = TW_RB;
            end
            TW_RB:
            begin
                a_next     = rd_data_reg;
                state_next = TW_RC;
            end
            TW_RC:
            begin
                b_next     = rd_data_reg;
                state_next = TW_RD;
            end
            TW_RD:
            begin
                // replace the word in place; later words read it as already twisted
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = TW_IDLE;
            end
            default:
            begin
                state_next = TW_IDLE;
            end
        endcase
        if (seed_we)
        begin
            seed_next  = seed_wdata;
            idx_next   = '0;
            state_next = TW_SEED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TW_SEED;
            seed_reg  <= SEED_RESET;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

/* hdl/gsg_radius.sv */
// Radius unit: sqrt(-2 ln u) in Q28 by normalise, log2 squaring and bitwise root.
module gsg_radius
    import gsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] x,
    output logic        done,
    output logic [30:0] r
);

    localparam logic [2:0] RA_IDLE = 3'd0;
    localparam logic [2:0] RA_NORM = 3'd1;
    localparam logic [2:0] RA_LOG  = 3'd2;
    localparam logic [2:0] RA_Y    = 3'd3;
    localparam logic [2:0] RA_MULL = 3'd4;
    localparam logic [2:0] RA_MULH = 3'd5;
    localparam logic [2:0] RA_SQRT = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        done_reg, done_next;
    logic [32:0] m_reg, m_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] f_reg, f_next;
    logic [31:0] frac_reg, frac_next;
    logic [4:0]  step_reg, step_next;
    logic [37:0] y_reg, y_next;
    logic [63:0] pl_reg, pl_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;

    logic [63:0] sq;
    logic [32:0] sq_t;
    logic [39:0] lh, l;
    logic [63:0] sum;

    assign done = done_reg;
    assign r    = res_reg[30:0];

    assign sq   = 64'(f_reg) * 64'(f_reg);
    assign sq_t = sq[63:31];
    assign lh   = 40'(y_reg[37:32]) * 40'(LN2_Q32);
    assign l    = (lh << 1) + 40'(pl_reg[63:31]);
    assign sum  = res_reg + bit_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        m_next     = m_reg;
        cnt_next   = cnt_reg;
        f_next     = f_reg;
        frac_next  = frac_reg;
        step_next  = step_reg;
        y_next     = y_reg;
        pl_next    = pl_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        case (state_reg)
            RA_IDLE:
            begin
                if (start)
                begin
                    m_next     = {x, 1'b1};
                    cnt_next   = '0;
                    state_next = RA_NORM;
                end
            end
            RA_NORM:
            begin
                // shift until the top bit lands in bit 32
                if (m_reg[32])
                begin
                    f_next     = m_reg[32:1];
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = RA_LOG;
                end
                else
                begin
                    m_next   = m_reg << 1;
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            RA_LOG:
            begin
                if (sq_t[32])
                begin
                    f_next = sq_t[32:1];
                    frac_next[5'd31 - step_reg] = 1'b1;
                end
                else
                begin
                    f_next = sq_t[31:0];
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    state_next = RA_Y;
                end
            end
            RA_Y:
            begin
                y_next     = {cnt_reg + 6'd1, 32'd0} - {6'd0, frac_reg};
                state_next = RA_MULL;
            end
            RA_MULL:
            begin
                pl_next    = 64'(y_reg[31:0]) * 64'(LN2_Q32);
                state_next = RA_MULH;
            end
            RA_MULH:
            begin
                v_next     = {l, 24'd0};
                res_next   = '0;
                bit_next   = 64'd1 << 62;
                step_next  = '0;
                state_next = RA_SQRT;
            end
            RA_SQRT:
            begin
                if (v_reg >= sum)
                begin
                    v_next   = v_reg - sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    done_next  = 1'b1;
                    state_next = RA_IDLE;
                end
            end
            default:
            begin
                state_next = RA_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RA_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        cnt_reg  <= cnt_next;
        f_reg    <= f_next;
        frac_reg <= frac_next;
        step_reg <= step_next;
        y_reg    <= y_next;
        pl_reg   <= pl_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
    end

endmodule

/* hdl/gsg_back.sv */
// Back end: command sequencer, CORDIC rotation, spare store and result register.
module gsg_back
    import gsg_pkg::*;
#(
    parameter int FRAC_BITS = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       seed_we,
    input  logic                       cmd_valid,
    input  logic                       cmd,
    output logic                       cmd_pop,
    output logic                       word_req,
    input  word_t                      word,
    output logic                       rad_start,
    output logic [31:0]                rad_x,
    input  logic                       rad_done,
    input  logic [30:0]                rad_r,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       from_spare
);

    localparam logic [2:0] BK_IDLE = 3'd0;
    localparam logic [2:0] BK_W1   = 3'd1;
    localparam logic [2:0] BK_W2   = 3'd2;
    localparam logic [2:0] BK_RAD  = 3'd3;
    localparam logic [2:0] BK_GAIN = 3'd4;
    localparam logic [2:0] BK_CORD = 3'd5;
    localparam logic [2:0] BK_MAP  = 3'd6;
    localparam logic [2:0] BK_OUT  = 3'd7;

    localparam int SH  = 28 - FRAC_BITS;
    localparam int SHR = (SH > 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;
    localparam logic signed [39:0] HALF    = 40'((2 ** SHR) / 2);
    localparam logic signed [39:0] SAT_MAX = 40'sd8388607;
    localparam logic signed [39:0] SAT_MIN = -40'sd8388608;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    function automatic logic signed [SAMPLE_W-1:0] to_sample(input logic signed [34:0] v);
        logic signed [39:0] t;
        t = 40'(v);
        t = (t + HALF) >>> SHR;
        t = t <<< SHL;
        if (t > SAT_MAX)
        begin
            t = SAT_MAX;
        end
        if (t < SAT_MIN)
        begin
            t = SAT_MIN;
        end
        return t[SAMPLE_W-1:0];
    endfunction

    logic [2:0]                 state_reg, state_next;
    logic                       r_ready_reg, r_ready_next;
    logic [31:0]                x2_reg, x2_next;
    logic [30:0]                r_reg, r_next;
    logic signed [34:0]         cx_reg, cx_next;
    logic signed [34:0]         cy_reg, cy_next;
    logic signed [34:0]         cz_reg, cz_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic                       res_spare_reg, res_spare_next;
    logic signed [SAMPLE_W-1:0] spare_reg, spare_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                       out_spare_reg, out_spare_next;

    logic [60:0]                gain_prod;
    logic signed [34:0]         dx, dy, ang, cos_v, sin_v;

    assign empty      = !out_valid_reg;
    assign sample     = out_sample_reg;
    assign from_spare = out_spare_reg;
    assign cmd_pop    = (state_reg == BK_IDLE) && cmd_valid;
    assign word_req   = (state_reg == BK_W1) || (state_reg == BK_W2);
    assign rad_x      = word.data;
    assign rad_start  = (state_reg == BK_W1) && word.valid;

    assign gain_prod  = 61'(r_reg) * 61'(CORDIC_GAIN_Q30);
    assign dx         = cy_reg >>> step_reg;
    assign dy         = cx_reg >>> step_reg;
    assign ang        = 35'(atan_turn(step_reg)) <<< 1;

    // quadrant folding by exact sign swaps
    always_comb
    begin
        case (x2_reg[31:30])
            2'd0:
            begin
                cos_v = cx_reg;
                sin_v = cy_reg;
            end
            2'd1:
            begin
                cos_v = -cy_reg;
                sin_v = cx_reg;
            end
            2'd2:
            begin
                cos_v = -cx_reg;
                sin_v = -cy_reg;
            end
            default:
            begin
                cos_v = cy_reg;
                sin_v = -cx_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        r_ready_next    = r_ready_reg;
        x2_next         = x2_reg;
        r_next          = r_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        step_next       = step_reg;
        res_next        = res_reg;
        res_spare_next  = res_spare_reg;
        spare_next      = spare_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_spare_next  = out_spare_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (rad_done)
        begin
            r_ready_next = 1'b1;
            r_next       = rad_r;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd == CMD_DRAW)
                    begin
                        state_next = BK_W1;
                    end
                    else
                    begin
                        res_next       = spare_reg;
                        res_spare_next = 1'b1;
                        state_next     = BK_OUT;
                    end
                end
            end
            BK_W1:
            begin
                // first word feeds the radius unit straight away
                if (word.valid)
                begin
                    r_ready_next = 1'b0;
                    state_next   = BK_W2;
                end
            end
            BK_W2:
            begin
                if (word.valid)
                begin
                    x2_next    = word.data;
                    state_next = BK_RAD;
                end
            end
            BK_RAD:
            begin
                if (r_ready_reg)
                begin
                    state_next = BK_GAIN;
                end
            end
            BK_GAIN:
            begin
                cx_next    = 35'(gain_prod[60:30]);
                cy_next    = '0;
                cz_next    = 35'({x2_reg[29:0], 1'b1});
                step_next  = '0;
                state_next = BK_CORD;
            end
            BK_CORD:
            begin
                if (!cz_reg[34])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - ang;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + ang;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = BK_MAP;
                end
            end
            BK_MAP:
            begin
                res_next       = to_sample(cos_v);
                res_spare_next = 1'b0;
                spare_next     = to_sample(sin_v);
                state_next     = BK_OUT;
            end
            BK_OUT:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_reg;
                    out_spare_next  = res_spare_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (seed_we)
        begin
            spare_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            r_ready_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            spare_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            r_ready_reg   <= r_ready_next;
            out_valid_reg <= out_valid_next;
            spare_reg     <= spare_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x2_reg         <= x2_next;
        r_reg          <= r_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        step_reg       <= step_next;
        res_reg        <= res_next;
        res_spare_reg  <= res_spare_next;
        out_sample_reg <= out_sample_next;
        out_spare_reg  <= out_spare_next;
    end

endmodule

/* hdl/gsg_checker.sv */
// Port-level checker of the Gaussian sample generator and its bind.
module gsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [23:0] sample,
    input logic        from_spare,
    input logic        seed_we
);

    logic last_draw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_draw_reg <= 1'b0;
        end
        else if (seed_we)
        begin
            last_draw_reg <= 1'b0;
        end
        else if (pop && !empty)
        begin
            last_draw_reg <= !from_spare;
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before pop");

    a_stable_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(sample) && $stable(from_spare)))
        else $error("waiting result changed");

    a_spare_follows_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && from_spare) |-> last_draw_reg)
        else $error("spare shown without preceding draw");

    a_draw_after_spare: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !from_spare) |-> !last_draw_reg)
        else $error("two draws in a row without a seed write");

    a_not_full_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !full)
        else $error("queue full straight after reset");

endmodule

bind gaussian_sample_generator_core gsg_checker u_checker (.*);
